// ===== rtl/csps_pkg.sv =====
package csps_pkg;

  localparam int CoordW = 32;
  localparam int CoefW = 38;
  localparam int OpaW = 41;
  localparam int OpbW = 18;
  localparam int ProdW = 59;
  localparam int TW = 17;
  localparam int TaccW = 23;
  localparam int AlphaW = 17;
  localparam int DetailW = 6;
  localparam int InvW = 17;
  localparam int TightW = 16;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 17;
  localparam int FifoDepth = 2;
  localparam int FifoPtrW = 1;
  localparam int RndW = ProdW - 13;
  localparam int SumW = RndW + 1;

  localparam logic [TW-1:0] TOne = 17'h10000;
  localparam logic signed [AlphaW-1:0] AlphaOne = 17'sd4096;
  localparam logic [DetailW-1:0] DetailReset = 6'd20;
  localparam logic [InvW-1:0] InvDetailReset = 17'd3277;
  localparam logic [TightW-1:0] TightnessReset = 16'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DETAIL     = 2'd0,
    CFG_INV_DETAIL = 2'd1,
    CFG_TIGHTNESS  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [DetailW-1:0]       detail;
    logic [InvW-1:0]          inv_detail;
    logic signed [TightW-1:0] tightness;
  } cfg_t;

  typedef struct packed {
    logic signed [CoefW-1:0]  a;
    logic signed [CoefW-1:0]  b;
    logic signed [CoefW-1:0]  c;
    logic signed [CoordW-1:0] p1;
  } coef_t;

  typedef struct packed {
    coef_t                    x;
    coef_t                    y;
    logic [DetailW-1:0]       n;
    logic [InvW-1:0]          step;
    logic signed [AlphaW-1:0] alpha;
  } seg_t;

  function automatic coef_t make_coef(input logic signed [CoordW-1:0] p0,
                                      input logic signed [CoordW-1:0] p1,
                                      input logic signed [CoordW-1:0] p2,
                                      input logic signed [CoordW-1:0] p3);
    logic signed [CoefW-1:0] e0, e1, e2, e3;
    coef_t r;
    e0 = CoefW'(p0);
    e1 = CoefW'(p1);
    e2 = CoefW'(p2);
    e3 = CoefW'(p3);
    r.a = -e0 + (e1 + (e1 <<< 1)) - (e2 + (e2 <<< 1)) + e3;
    r.b = (e0 <<< 1) - (e1 + (e1 <<< 2)) + (e2 <<< 2) - e3;
    r.c = e2 - e0;
    r.p1 = p1;
    return r;
  endfunction

  // unsigned q1.16 product back to q1.16, round half up
  function automatic logic [TW-1:0] round_t(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] s;
    s = p + ProdW'(32768);
    return s[TW+15:16];
  endfunction

  function automatic logic signed [OpaW-1:0] round_s(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] s;
    s = p + ProdW'(32768);
    return $signed(s[OpaW+15:16]);
  endfunction

  function automatic logic signed [CoordW-1:0] finish(input logic signed [ProdW-1:0] p,
                                                     input logic signed [CoordW-1:0] p1);
    logic signed [ProdW-1:0] s;
    logic signed [SumW-1:0] v;
    s = p + ProdW'(4096);
    v = SumW'($signed(s[ProdW-1:13])) + SumW'(p1);
    if ((&v[SumW-1:CoordW-1]) || !(|v[SumW-1:CoordW-1])) begin
      return v[CoordW-1:0];
    end else if (v[SumW-1]) begin
      return {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      return {1'b0, {(CoordW-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/csps_ifaces.sv =====
interface csps_point_if;
  import csps_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] px;
  logic signed [CoordW-1:0] py;
  modport source(output valid, px, py, input ready);
  modport sink(input valid, px, py, output ready);
endinterface

interface csps_sample_if;
  import csps_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] qx;
  logic signed [CoordW-1:0] qy;
  logic                     last;
  modport source(output valid, qx, qy, last, input ready);
  modport sink(input valid, qx, qy, last, output ready);
endinterface

interface csps_cfg_if;
  import csps_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/csps_cfg_regs.sv =====
module csps_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  csps_cfg_if.sink      cfg,
  output csps_pkg::cfg_t regs
);
  import csps_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.detail <= DetailReset;
      regs.inv_detail <= InvDetailReset;
      regs.tightness <= TightnessReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_DETAIL:     regs.detail <= cfg.data[DetailW-1:0];
        CFG_INV_DETAIL: regs.inv_detail <= cfg.data[InvW-1:0];
        CFG_TIGHTNESS:  regs.tightness <= $signed(cfg.data[TightW-1:0]);
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/csps_front.sv =====
module csps_front (
  input  logic           clk,
  input  logic           rst,
  csps_point_if.sink     points,
  input  csps_pkg::cfg_t regs,
  input  logic           full,
  output logic           push,
  output csps_pkg::seg_t push_data
);
  import csps_pkg::*;

  logic [1:0]               point_count;
  logic signed [CoordW-1:0] point_x_store [3];
  logic signed [CoordW-1:0] point_y_store [3];
  logic                     accept;

  assign points.ready = !((point_count == 2'd3) && full);
  assign accept = points.valid && points.ready;
  assign push = accept && (point_count == 2'd3);

  always_comb begin
    push_data.x = make_coef(point_x_store[0], point_x_store[1], point_x_store[2], points.px);
    push_data.y = make_coef(point_y_store[0], point_y_store[1], point_y_store[2], points.py);
    push_data.n = regs.detail;
    push_data.step = regs.inv_detail;
    push_data.alpha = AlphaOne - AlphaW'(regs.tightness);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= 2'd0;
    end else if (accept) begin
      point_count <= point_count + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (point_count != 2'd3)) begin
      point_x_store[point_count] <= points.px;
      point_y_store[point_count] <= points.py;
    end
  end
endmodule

// ===== rtl/csps_seg_fifo.sv =====
module csps_seg_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  csps_pkg::seg_t push_data,
  input  logic           pop,
  output csps_pkg::seg_t pop_data,
  output logic           full,
  output logic           empty
);
  import csps_pkg::*;

  seg_t                mem [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr;
  logic [FifoPtrW-1:0] rd_ptr;
  logic [FifoPtrW:0]   count;

  assign full = (count == (FifoPtrW + 1)'(FifoDepth));
  assign empty = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end
endmodule

// ===== rtl/csps_back.sv =====
module csps_back (
  input  logic           clk,
  input  logic           rst,
  input  csps_pkg::seg_t pop_data,
  input  logic           empty,
  output logic           pop,
  csps_sample_if.source  samples
);
  import csps_pkg::*;

  typedef enum logic [3:0] {
    IDLE, S_TT, S_CXT, S_T2T, S_BXT2, S_AT3, S_ACC, S_SHIFT, S_SCALE, S_OUT
  } state_t;

  state_t                  state;
  seg_t                    seg;
  logic [DetailW-1:0]      j;
  logic [TaccW-1:0]        t_acc;
  logic [TW-1:0]           t;
  logic [TW-1:0]           t2;
  logic [TW-1:0]           t3;
  logic signed [ProdW-1:0] prod_x, prod_y;
  logic signed [ProdW-1:0] acc_x, acc_y;
  logic signed [OpaW-1:0]  s_x, s_y;
  logic signed [OpaW-1:0]  opa_x, opa_y;
  logic signed [OpbW-1:0]  opb_x, opb_y;
  logic signed [ProdW-1:0] mul_x, mul_y;
  logic                    out_free;

  assign pop = (state == IDLE) && !empty;
  assign t = (t_acc > TaccW'(TOne)) ? TOne : t_acc[TW-1:0];
  assign out_free = !samples.valid || samples.ready;

  always_comb begin
    opa_x = OpaW'($signed({1'b0, t}));
    opb_x = OpbW'($signed({1'b0, t}));
    opa_y = OpaW'(seg.y.c);
    opb_y = OpbW'($signed({1'b0, t}));
    unique case (state)
      S_CXT: begin
        opa_x = OpaW'(seg.x.c);
      end
      S_T2T: begin
        opa_x = OpaW'($signed({1'b0, t2}));
        opa_y = OpaW'(seg.y.b);
        opb_y = OpbW'($signed({1'b0, t2}));
      end
      S_BXT2: begin
        opa_x = OpaW'(seg.x.b);
        opb_x = OpbW'($signed({1'b0, t2}));
      end
      S_AT3: begin
        opa_x = OpaW'(seg.x.a);
        opb_x = OpbW'($signed({1'b0, t3}));
        opa_y = OpaW'(seg.y.a);
        opb_y = OpbW'($signed({1'b0, t3}));
      end
      S_SCALE: begin
        opa_x = s_x;
        opb_x = OpbW'(seg.alpha);
        opa_y = s_y;
        opb_y = OpbW'(seg.alpha);
      end
      default: ;
    endcase
  end

  assign mul_x = opa_x * opb_x;
  assign mul_y = opa_y * opb_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      samples.valid <= 1'b0;
    end else begin
      if (samples.valid && samples.ready && (state != S_OUT)) samples.valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (!empty) begin
            seg <= pop_data;
            j <= '0;
            t_acc <= '0;
            state <= S_TT;
          end
        end
        S_TT: begin
          prod_x <= mul_x;
          prod_y <= mul_y;
          state <= S_CXT;
        end
        S_CXT: begin
          t2 <= round_t(prod_x);
          acc_y <= prod_y;
          prod_x <= mul_x;
          state <= S_T2T;
        end
        S_T2T: begin
          acc_x <= prod_x;
          prod_x <= mul_x;
          prod_y <= mul_y;
          state <= S_BXT2;
        end
        S_BXT2: begin
          t3 <= round_t(prod_x);
          acc_y <= acc_y + prod_y;
          prod_x <= mul_x;
          state <= S_AT3;
        end
        S_AT3: begin
          acc_x <= acc_x + prod_x;
          prod_x <= mul_x;
          prod_y <= mul_y;
          state <= S_ACC;
        end
        S_ACC: begin
          acc_x <= acc_x + prod_x;
          acc_y <= acc_y + prod_y;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          s_x <= round_s(acc_x);
          s_y <= round_s(acc_y);
          state <= S_SCALE;
        end
        S_SCALE: begin
          prod_x <= mul_x;
          prod_y <= mul_y;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            samples.valid <= 1'b1;
            samples.qx <= finish(prod_x, seg.x.p1);
            samples.qy <= finish(prod_y, seg.y.p1);
            samples.last <= (j == seg.n);
            if (j == seg.n) begin
              state <= IDLE;
            end else begin
              j <= j + 1'b1;
              t_acc <= t_acc + TaccW'(seg.step);
              state <= S_TT;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/cardinal_spline_point_stream.sv =====
// first sample: a segment's samples start once its fourth point transfer is queued and the
// sequencer takes it in IDLE; each sample steps S_TT, S_CXT, S_T2T, S_BXT2, S_AT3, S_ACC,
//   S_SHIFT, S_SCALE and S_OUT, and S_OUT waits while the sample output is stalled
// the two-entry segment queue lets the front take the next group while samples go out
// reset: synchronous, clears point count, queue and sequencer; registers return to defaults
module cardinal_spline_point_stream (
  input logic           clk,
  input logic           rst,
  csps_point_if.sink    points,
  csps_sample_if.source samples,
  csps_cfg_if.sink      cfg
);
  import csps_pkg::*;

  cfg_t regs;
  seg_t push_data;
  seg_t pop_data;
  logic push;
  logic pop;
  logic full;
  logic empty;

  csps_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  csps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .points    (points),
    .regs      (regs),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  csps_seg_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  csps_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (pop_data),
    .empty    (empty),
    .pop      (pop),
    .samples  (samples)
  );
endmodule

// ===== bench/cardinal_spline_point_stream_tb.sv =====
`timescale 1ns / 1ps

module cardinal_spline_point_stream_tb;
  import csps_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD = 800;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;
  localparam logic signed [CoordW-1:0] CoordMax = 32'sh7fffffff;
  localparam logic signed [CoordW-1:0] CoordMin = 32'sh80000000;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } point_t;

  typedef struct packed {
    logic signed [CoordW-1:0] qx;
    logic signed [CoordW-1:0] qy;
    logic                     last;
  } sample_t;

  logic clk;
  logic rst;

  csps_point_if  pt_if();
  csps_sample_if smp_if();
  csps_cfg_if    cfg_if();

  cardinal_spline_point_stream uut (
    .clk(clk),
    .rst(rst),
    .points(pt_if),
    .samples(smp_if),
    .cfg(cfg_if)
  );

  point_t  send_q[$];
  sample_t curve_q[$];
  sample_t head;

  logic [DetailW-1:0]       cur_detail;
  logic [InvW-1:0]          cur_step;
  logic signed [TightW-1:0] cur_tight;
  longint                   held_x[4];
  longint                   held_y[4];
  int unsigned              held_count;

  logic pt_taken;
  int   pt_gap;
  int   rx_gap;
  int   hold_left;
  int   hold_req;
  int   hold_served;
  bit   pt_idling;
  bit   rx_idling;

  int err_count;
  int cycle_count;
  int pts_sent;
  int samples_checked;
  int settings_used;

  function automatic longint round_half_up(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [CoordW-1:0] seg_coord(input longint p[4], input longint alpha,
                                                         input longint t, input longint t2,
                                                         input longint t3);
    longint ca, cb, cc, acc, r;
    ca = -p[0] + 3 * p[1] - 3 * p[2] + p[3];
    cb = 2 * p[0] - 5 * p[1] + 4 * p[2] - p[3];
    cc = p[2] - p[0];
    acc = ca * t3 + cb * t2 + cc * t;
    r = round_half_up(alpha * round_half_up(acc, 16), 13) + p[1];
    if (r > longint'(CoordMax)) r = longint'(CoordMax);
    if (r < longint'(CoordMin)) r = longint'(CoordMin);
    return CoordW'(r);
  endfunction

  // buffer one control point; the fourth one of a group yields a whole segment
  task automatic take_point(input point_t p);
    longint      alpha, t, t2, t3;
    int unsigned n;
    sample_t     s;
    held_x[held_count] = longint'($signed(p.x));
    held_y[held_count] = longint'($signed(p.y));
    if (held_count != 3) begin
      held_count++;
      return;
    end
    held_count = 0;
    n = cur_detail;
    alpha = longint'(AlphaOne) - longint'(cur_tight);
    for (int j = 0; j <= n; j++) begin
      t = longint'(j) * longint'(cur_step);
      if (t > longint'(TOne)) t = longint'(TOne);
      t2 = (t * t + 32768) >> 16;
      t3 = (t2 * t + 32768) >> 16;
      s.qx = seg_coord(held_x, alpha, t, t2, t3);
      s.qy = seg_coord(held_y, alpha, t, t2, t3);
      s.last = (j == n);
      curve_q = {curve_q, s};
    end
  endtask

  function automatic logic signed [CoordW-1:0] pick_coord();
    logic signed [CoordW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = CoordMax;
      1: v = CoordMin;
      2, 3: v = $urandom();
      default: v = $signed(CoordW'($urandom_range(0, 2097151))) - 32'sd1048576;
    endcase
    return v;
  endfunction

  task automatic push_point(input logic signed [CoordW-1:0] x, input logic signed [CoordW-1:0] y);
    point_t p;
    p.x = x;
    p.y = y;
    send_q = {send_q, p};
  endtask

  task automatic push_random_group();
    logic signed [CoordW-1:0] bx, by;
    bit                       spread;
    spread = ($urandom_range(0, 2) == 0);
    bx = pick_coord();
    by = pick_coord();
    for (int k = 0; k < 4; k++) begin
      if (spread) begin
        push_point(pick_coord(), pick_coord());
      end else begin
        push_point(bx + $signed(CoordW'($urandom_range(0, 262143))) - 32'sd131072,
                   by + $signed(CoordW'($urandom_range(0, 262143))) - 32'sd131072);
      end
    end
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_DETAIL: cur_detail = data[DetailW-1:0];
      CFG_INV_DETAIL: cur_step = data[InvW-1:0];
      CFG_TIGHTNESS: cur_tight = data[TightW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_phase(input int p);
    logic [DetailW-1:0]       d;
    logic [InvW-1:0]          s;
    logic signed [TightW-1:0] tg;
    d = DetailW'($urandom_range(1, 16));
    if ($urandom_range(0, 3) == 0) d = DetailW'($urandom_range(0, 63));
    if (d != 0 && $urandom_range(0, 1) == 1) begin
      s = InvW'((65536 + d / 2) / d);
    end else begin
      s = InvW'($urandom_range(0, 131071));
    end
    tg = TightW'($urandom());
    case (p)
      0: d = 6'd0;
      1: begin
        d = 6'd63;
        s = 17'd1040;
        tg = 16'sd0;
      end
      2: begin
        d = 6'd3;
        s = 17'd21845;
        tg = 16'sh8000;
      end
      3: begin
        d = 6'd7;
        s = 17'h1ffff;
        tg = 16'sh7fff;
      end
      4: begin
        d = 6'd1;
        s = TOne;
        tg = 16'sd4096;
      end
      5: begin
        d = 6'd12;
        s = 17'd0;
      end
      default: ;
    endcase
    cfg_write(CFG_DETAIL, CfgDataW'(d));
    cfg_write(CFG_INV_DETAIL, s);
    cfg_write(CFG_TIGHTNESS, CfgDataW'($unsigned(tg)));
    if (p == 5 || p == 8) cfg_write(CfgIdxSpare, CfgDataW'($urandom()));
  endtask

  task automatic wait_drained();
    while (send_q.size() != 0 || pt_if.valid || curve_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("cardinal_spline_point_stream_tb: errors");
      $finish;
    end
  end

  // point driver
  always @(negedge clk) begin
    if (rst) begin
      pt_if.valid <= 1'b0;
    end else if (pt_if.valid && !pt_taken) begin
      // offered point not taken yet, keep it
    end else if (pt_gap > 0) begin
      pt_gap <= pt_gap - 1;
      pt_if.valid <= 1'b0;
    end else if (pt_idling && $urandom_range(0, 5) == 0) begin
      pt_gap <= $urandom_range(0, 11);
      pt_if.valid <= 1'b0;
    end else if (send_q.size() != 0) begin
      pt_if.px <= send_q[0].x;
      pt_if.py <= send_q[0].y;
      void'(send_q.pop_front());
      pt_if.valid <= 1'b1;
    end else begin
      pt_if.valid <= 1'b0;
    end
  end

  // sample receiver
  always @(negedge clk) begin
    if (rst) begin
      smp_if.ready <= 1'b0;
    end else if (hold_served != hold_req) begin
      hold_served <= hold_req;
      hold_left <= LONG_HOLD - 1;
      smp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      smp_if.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      smp_if.ready <= 1'b0;
    end else if (rx_idling && $urandom_range(0, 5) == 0) begin
      rx_gap <= $urandom_range(0, 11);
      smp_if.ready <= 1'b0;
    end else begin
      smp_if.ready <= 1'b1;
    end
  end

  // monitor: check each sample transfer, predict on each point transfer
  always @(posedge clk) begin
    pt_taken <= pt_if.valid && pt_if.ready;
    if (!rst && smp_if.valid && smp_if.ready) begin
      if (curve_q.size() == 0) begin
        $error("sample with no expectation waiting: qx %0d qy %0d last %0d",
               smp_if.qx, smp_if.qy, smp_if.last);
        err_count++;
      end else begin
        head = curve_q.pop_front();
        samples_checked++;
        if (smp_if.qx !== head.qx) begin
          $error("qx mismatch: expected %0d, got %0d", head.qx, smp_if.qx);
          err_count++;
        end
        if (smp_if.qy !== head.qy) begin
          $error("qy mismatch: expected %0d, got %0d", head.qy, smp_if.qy);
          err_count++;
        end
        if (smp_if.last !== head.last) begin
          $error("last mismatch: expected %0d, got %0d", head.last, smp_if.last);
          err_count++;
        end
      end
    end
    if (!rst && pt_if.valid && pt_if.ready) begin
      pts_sent++;
      take_point({pt_if.px, pt_if.py});
    end
  end

  initial begin
    rst = 1'b1;
    pt_if.valid = 1'b0;
    pt_if.px = '0;
    pt_if.py = '0;
    smp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    cur_detail = DetailReset;
    cur_step = InvDetailReset;
    cur_tight = TightnessReset;
    held_count = 0;
    pt_taken = 1'b0;
    pt_gap = 0;
    rx_gap = 0;
    hold_left = 0;
    hold_req = 0;
    hold_served = 0;
    pt_idling = 1'b1;
    rx_idling = 1'b1;
    err_count = 0;
    cycle_count = 0;
    pts_sent = 0;
    samples_checked = 0;
    settings_used = 1;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: twenty intervals whose last step overshoots one
    for (int k = 0; k < 4; k++) push_point(0, 0);
    for (int k = 0; k < 4; k++) push_point(CoordMax, CoordMax);
    for (int k = 0; k < 4; k++) push_point(CoordMin, CoordMin);
    for (int k = 0; k < 4; k++) begin
      push_point(k % 2 ? CoordMax : CoordMin, k % 2 ? CoordMin : CoordMax);
    end
    for (int k = 0; k < 4; k++) begin
      push_point(k % 2 ? CoordMin : CoordMax, k % 2 ? CoordMax : CoordMin);
    end
    for (int k = 0; k < 4; k++) begin
      push_point(k % 2 ? 32'sh55555555 : 32'shaaaaaaaa, k % 2 ? 32'shaaaaaaaa : 32'sh55555555);
    end
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      set_phase(p);
      settings_used++;
      pt_idling = (p != 9) && ($urandom_range(0, 3) != 0);
      rx_idling = (p != 9) && ($urandom_range(0, 3) != 0);
      for (int g = 0; g < ((p == 1) ? 2 : (p == 2) ? 8 : (p < 6) ? 4 : 5); g++) begin
        push_random_group();
      end
      // stall the output long enough for the segment queue to back up into the input
      if (p == 2) hold_req++;
      wait_drained();
    end

    // an incomplete group must not produce samples
    for (int k = 0; k < $urandom_range(1, 3); k++) push_point(pick_coord(), pick_coord());
    wait_drained();

    $display("covered %0d point transfers and %0d checked samples over %0d register settings",
             pts_sent, samples_checked, settings_used);
    $display("settings spanned detail 0 and 63, steps past one, tightness extremes, spare index");
    if (err_count == 0) begin
      $display("cardinal_spline_point_stream_tb: clean");
    end else begin
      $display("cardinal_spline_point_stream_tb: errors");
    end
    $finish;
  end

endmodule
